FILE: rtl/t7d_pkg.sv
// Shared constants, key table and character class type for the type 7 decoder.
`default_nettype none

package t7d_pkg;

    localparam int CHAR_W  = 8;
    localparam int NIB_W   = 4;
    localparam int KEY_LEN = 53;
    localparam int KEY_W   = $clog2(KEY_LEN);
    localparam int SEED_W  = 7;

    localparam logic [CHAR_W-1:0] KEY_TABLE [KEY_LEN] = '{
        8'h64, 8'h73, 8'h66, 8'h64, 8'h3b, 8'h6b, 8'h66, 8'h6f,
        8'h41, 8'h2c, 8'h2e, 8'h69, 8'h79, 8'h65, 8'h77, 8'h72,
        8'h6b, 8'h6c, 8'h64, 8'h4a, 8'h4b, 8'h44, 8'h48, 8'h53,
        8'h55, 8'h42, 8'h73, 8'h67, 8'h76, 8'h63, 8'h61, 8'h36,
        8'h39, 8'h38, 8'h33, 8'h34, 8'h6e, 8'h63, 8'h78, 8'h76,
        8'h39, 8'h38, 8'h37, 8'h33, 8'h32, 8'h35, 8'h34, 8'h6b,
        8'h3b, 8'h66, 8'h67, 8'h38, 8'h37
    };

    typedef struct packed {
        logic             dec_ok;
        logic [NIB_W-1:0] dec_val;
        logic             hex_ok;
        logic [NIB_W-1:0] hex_val;
    } t_char_info;

endpackage

`default_nettype wire

FILE: rtl/t7d_char_decode.sv
// Classifies one ASCII character as a decimal digit or a hex digit and gives its value.
`default_nettype none

module t7d_char_decode (
    input  wire logic [t7d_pkg::CHAR_W-1:0] i_char,
    output t7d_pkg::t_char_info             o_info
);
    import t7d_pkg::*;

    logic w_digit;
    logic w_lower;
    logic w_upper;

    always_comb begin
        w_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
        w_lower = (i_char >= 8'h61) && (i_char <= 8'h66);
        w_upper = (i_char >= 8'h41) && (i_char <= 8'h46);

        o_info.dec_ok  = w_digit;
        o_info.dec_val = w_digit ? i_char[NIB_W-1:0] : '0;
        o_info.hex_ok  = w_digit || w_lower || w_upper;
        if (w_digit) begin
            o_info.hex_val = i_char[NIB_W-1:0];
        end else if (w_lower || w_upper) begin
            o_info.hex_val = i_char[NIB_W-1:0] + NIB_W'(9);
        end else begin
            o_info.hex_val = '0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/type7_password_decoder.sv
// Streaming type 7 password decoder, one character per cycle while not stalled.
// The input channel (i_valid, i_hash_char, i_final_char, o_stall) carries one
// ASCII character per request; i_final_char marks the last character of a string.
// The first two characters form a decimal seed, each later pair of hex digits
// yields one plaintext byte on the output channel (o_valid, o_plain_byte,
// o_error, o_last, i_stall). A character that closes a pair, or the final
// character, produces one result; other characters produce none.
// o_error is set only on the last result of a string, and o_plain_byte is zero
// whenever the string is already known to be malformed.
// An accepted request is held in the input register, and its result in the output
// register until the receiver takes it. Throughput is one character per cycle
// while the receiver does not stall.
// When the receiver stalls with a result pending, the output register and the
// input register hold, and o_stall rises once the input register is occupied.
// Synchronous reset clears both valid flags and returns the parser to the seed.
// After a final character the parser returns to its reset state by itself.
`default_nettype none

module type7_password_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [t7d_pkg::CHAR_W-1:0]  i_hash_char,
    input  wire logic                        i_final_char,
    output logic                             o_stall,
    output logic                             o_valid,
    output logic [t7d_pkg::CHAR_W-1:0]       o_plain_byte,
    output logic                             o_error,
    output logic                             o_last,
    input  wire logic                        i_stall
);
    import t7d_pkg::*;

    typedef enum logic [1:0] {
        PH_SEED_TENS,
        PH_SEED_ONES,
        PH_HIGH,
        PH_LOW
    } t_phase;

    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_in_char;
    logic                r_in_final;

    t_phase              r_phase, n_phase;
    logic [NIB_W-1:0]    r_seed_tens, n_seed_tens;
    logic [KEY_W-1:0]    r_key_index, n_key_index;
    logic [NIB_W-1:0]    r_high_nibble, n_high_nibble;
    logic                r_error_seen, n_error_seen;

    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_byte, n_out_byte;
    logic                r_out_error, n_out_error;
    logic                r_out_last, n_out_last;

    t_char_info          w_info;
    logic                w_out_free;
    logic                w_proc;
    logic                w_accept;
    logic [SEED_W-1:0]   w_seed_sum;
    logic [KEY_W-1:0]    w_seed_mod;
    logic                w_emit;
    logic                w_bad;
    logic                w_err_now;
    logic [CHAR_W-1:0]   w_byte;

    t7d_char_decode u_char_decode (
        .i_char (r_in_char),
        .o_info (w_info)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    assign o_valid      = r_out_valid;
    assign o_plain_byte = r_out_byte;
    assign o_error      = r_out_error;
    assign o_last       = r_out_last;

    always_comb begin
        w_seed_sum = SEED_W'(r_seed_tens) * SEED_W'(10) + SEED_W'(w_info.dec_val);
        if (w_seed_sum >= SEED_W'(KEY_LEN)) begin
            w_seed_mod = KEY_W'(w_seed_sum - SEED_W'(KEY_LEN));
        end else begin
            w_seed_mod = KEY_W'(w_seed_sum);
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_seed_tens   = r_seed_tens;
        n_key_index   = r_key_index;
        n_high_nibble = r_high_nibble;
        w_emit        = 1'b0;
        w_bad         = 1'b0;
        w_byte        = '0;

        unique case (r_phase)
            PH_SEED_TENS: begin
                n_seed_tens = w_info.dec_val;
                w_bad       = !w_info.dec_ok;
                n_phase     = PH_SEED_ONES;
            end
            PH_SEED_ONES: begin
                n_key_index = w_seed_mod;
                w_bad       = !w_info.dec_ok;
                n_phase     = PH_HIGH;
            end
            PH_HIGH: begin
                n_high_nibble = w_info.hex_val;
                w_bad         = !w_info.hex_ok;
                n_phase       = PH_LOW;
            end
            PH_LOW: begin
                w_byte = {r_high_nibble, w_info.hex_val} ^ KEY_TABLE[r_key_index];
                if (r_key_index == KEY_W'(KEY_LEN - 1)) begin
                    n_key_index = '0;
                end else begin
                    n_key_index = r_key_index + KEY_W'(1);
                end
                w_bad   = !w_info.hex_ok;
                w_emit  = 1'b1;
                n_phase = PH_HIGH;
            end
            default: begin
                n_phase = PH_SEED_TENS;
            end
        endcase

        w_err_now    = r_error_seen || w_bad;
        n_error_seen = w_err_now;

        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_error = r_out_error;
        n_out_last  = r_out_last;

        if (r_in_final) begin
            n_out_valid   = 1'b1;
            n_out_error   = w_err_now || !w_emit;
            n_out_byte    = (w_err_now || !w_emit) ? '0 : w_byte;
            n_out_last    = 1'b1;
            n_phase       = PH_SEED_TENS;
            n_seed_tens   = '0;
            n_key_index   = '0;
            n_high_nibble = '0;
            n_error_seen  = 1'b0;
        end else if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_error = 1'b0;
            n_out_byte  = w_err_now ? '0 : w_byte;
            n_out_last  = 1'b0;
        end

        if (!w_proc) begin
            n_phase       = r_phase;
            n_seed_tens   = r_seed_tens;
            n_key_index   = r_key_index;
            n_high_nibble = r_high_nibble;
            n_error_seen  = r_error_seen;
            n_out_valid   = r_out_valid && i_stall;
            n_out_byte    = r_out_byte;
            n_out_error   = r_out_error;
            n_out_last    = r_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_phase       <= PH_SEED_TENS;
            r_seed_tens   <= '0;
            r_key_index   <= '0;
            r_high_nibble <= '0;
            r_error_seen  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            r_phase       <= n_phase;
            r_seed_tens   <= n_seed_tens;
            r_key_index   <= n_key_index;
            r_high_nibble <= n_high_nibble;
            r_error_seen  <= n_error_seen;
            r_out_valid   <= n_out_valid;
        end
        if (w_accept) begin
            r_in_char  <= i_hash_char;
            r_in_final <= i_final_char;
        end
        r_out_byte  <= n_out_byte;
        r_out_error <= n_out_error;
        r_out_last  <= n_out_last;
    end

`ifndef ASSERT_OFF
    a_error_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> !r_out_error)
        else $error("Error flag set on a result that is not the last.");

    a_error_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_error) |-> (r_out_byte == '0))
        else $error("Nonzero byte on a result that carries an error.");

    a_key_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_index < KEY_W'(KEY_LEN))
        else $error("Key index outside the key table.");

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_final) |=> (r_phase == PH_SEED_TENS) && !r_error_seen)
        else $error("Parser state not cleared after the final character.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("Input stall raised without a blocked result.");
`endif

endmodule

`default_nettype wire
